// ===== rtl/ppc_pkg.sv =====
package ppc_pkg;

    // Register map of the configuration port.
    localparam logic [2:0] REG_DEGREE  = 3'd0;
    localparam logic [2:0] REG_COEF_01 = 3'd1;
    localparam logic [2:0] REG_COEF_89 = 3'd5;

    localparam int NUM_COEF_REGS = 5;
    localparam int NUM_COEFS     = 2 * NUM_COEF_REGS;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DEGREE_W   = 4;
    localparam int SAMPLE_W   = 32;
    localparam int PROD_W     = 2 * SAMPLE_W;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic [CFG_DATA_W-1:0]      t_coef_reg;

    localparam logic [DEGREE_W-1:0] DEGREE_RESET = 4'd3;

    localparam t_coef_reg COEF_RESET [NUM_COEF_REGS] = '{
        64'd63338625743454208,
        64'd7191347213155015,
        64'd0,
        64'd0,
        64'd0
    };

    // Clamp limits of the accumulator, sign-extended to the product width.
    localparam t_prod SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam t_prod SAT_LO = 64'shFFFF_FFFF_8000_0000;

endpackage

// ===== rtl/polynomial_pixel_correction_top.sv =====
// Polynomial pixel correction: p(x) = c0 + c1*x + ... + cd*x^d in signed Q8.24,
// evaluated by Horner's rule, one step per pipeline pair.
//
// Input: raise start with a sample word on i_sample_in and i_last_in; the word
// is taken at a rising edge where start is high and busy is low. busy is high
// only in the cycle after reset, so a new word can be taken every cycle.
// Output: o_strobe is high for exactly one cycle with o_sample_out, o_overflow
// and o_last_out. The receiver cannot stall, so the pipeline never holds.
// A word passes the input register and then every step; throughput is one word
// per cycle. Each Horner step is one 32x32 signed multiply stage followed by a
// shift, coefficient add and saturate stage; steps for coefficients at or
// above the configured degree pass the accumulator through unchanged.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data. Index 0
// is the degree (writes outside 1..MAX_DEGREE are dropped), indices 1 to 5
// hold coefficient pairs, low word even and high word odd. Other indices do
// nothing. Write only while no word is in flight.
// Reset (synchronous, active low) empties the pipeline and restores the
// degree to 3 and the coefficients to their default curve.
module polynomial_pixel_correction_top #(
    parameter int MAX_DEGREE = 9,
    parameter int FRAC_BITS  = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [ppc_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic                                 i_last_in,
    input  logic                                 i_cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ppc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                 o_strobe,
    output logic signed [ppc_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                 o_overflow,
    output logic                                 o_last_out
);

    localparam int LATENCY = 1 + 2 * MAX_DEGREE;

    // Configuration registers.
    logic [ppc_pkg::DEGREE_W-1:0] r_degree;
    ppc_pkg::t_coef_reg           r_coef [ppc_pkg::NUM_COEF_REGS];
    logic                         r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= ppc_pkg::DEGREE_RESET;
            r_coef   <= ppc_pkg::COEF_RESET;
            r_busy   <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == ppc_pkg::REG_DEGREE) begin
                    if (i_cfg_data >= 64'd1 && i_cfg_data <= 64'(MAX_DEGREE)) begin
                        r_degree <= i_cfg_data[ppc_pkg::DEGREE_W-1:0];
                    end
                end else if (i_cfg_idx >= ppc_pkg::REG_COEF_01
                             && i_cfg_idx <= ppc_pkg::REG_COEF_89) begin
                    r_coef[i_cfg_idx - ppc_pkg::REG_COEF_01] <= i_cfg_data;
                end
            end
        end
    end

    assign busy = r_busy;

    // Coefficients unpacked into single signed words.
    ppc_pkg::t_sample coef_w [ppc_pkg::NUM_COEFS];

    for (genvar c = 0; c < ppc_pkg::NUM_COEFS; c++) begin : g_coef
        if (c % 2 == 1) begin : g_odd
            assign coef_w[c] = r_coef[c/2][63:32];
        end else begin : g_even
            assign coef_w[c] = r_coef[c/2][31:0];
        end
    end

    // The degree register can only exceed MAX_DEGREE through its reset value.
    logic [ppc_pkg::DEGREE_W-1:0] deg_eff;
    assign deg_eff = (r_degree > ppc_pkg::DEGREE_W'(MAX_DEGREE))
                   ? ppc_pkg::DEGREE_W'(MAX_DEGREE) : r_degree;

    logic accept;
    assign accept = start && !r_busy;

    // Accumulate stage outputs; index 0 is the input register holding the
    // leading coefficient as the starting accumulator.
    ppc_pkg::t_sample r_a_acc  [MAX_DEGREE+1];
    ppc_pkg::t_sample r_a_x    [MAX_DEGREE];
    logic             r_a_last [MAX_DEGREE+1];
    logic             r_a_ovf  [MAX_DEGREE+1];
    logic             r_a_vld  [MAX_DEGREE+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld[0] <= 1'b0;
        end else begin
            r_a_vld[0] <= accept;
        end
        r_a_acc[0]  <= coef_w[deg_eff];
        r_a_x[0]    <= i_sample_in;
        r_a_last[0] <= i_last_in;
        r_a_ovf[0]  <= 1'b0;
    end

    // Multiply stage outputs.
    ppc_pkg::t_prod   r_m_prod [MAX_DEGREE];
    ppc_pkg::t_sample r_m_acc  [MAX_DEGREE];
    ppc_pkg::t_sample r_m_x    [MAX_DEGREE];
    logic             r_m_last [MAX_DEGREE];
    logic             r_m_ovf  [MAX_DEGREE];
    logic             r_m_vld  [MAX_DEGREE];

    for (genvar s = 0; s < MAX_DEGREE; s++) begin : g_step
        // Step s folds in coefficient k; it is active only when k < degree.
        localparam int K = MAX_DEGREE - 1 - s;

        ppc_pkg::t_prod   shifted;
        ppc_pkg::t_prod   sum;
        logic             active;
        ppc_pkg::t_sample n_acc;
        logic             n_ovf;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_vld[s] <= 1'b0;
            end else begin
                r_m_vld[s] <= r_a_vld[s];
            end
            r_m_prod[s] <= ppc_pkg::t_prod'(r_a_acc[s]) * ppc_pkg::t_prod'(r_a_x[s]);
            r_m_acc[s]  <= r_a_acc[s];
            r_m_x[s]    <= r_a_x[s];
            r_m_last[s] <= r_a_last[s];
            r_m_ovf[s]  <= r_a_ovf[s];
        end

        assign shifted = r_m_prod[s] >>> FRAC_BITS;
        assign sum     = shifted + ppc_pkg::t_prod'(coef_w[K]);
        assign active  = ppc_pkg::DEGREE_W'(K) < deg_eff;

        always_comb begin
            n_acc = r_m_acc[s];
            n_ovf = r_m_ovf[s];
            if (active) begin
                if (sum > ppc_pkg::SAT_HI) begin
                    n_acc = ppc_pkg::SAT_HI[ppc_pkg::SAMPLE_W-1:0];
                    n_ovf = 1'b1;
                end else if (sum < ppc_pkg::SAT_LO) begin
                    n_acc = ppc_pkg::SAT_LO[ppc_pkg::SAMPLE_W-1:0];
                    n_ovf = 1'b1;
                end else begin
                    n_acc = sum[ppc_pkg::SAMPLE_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_vld[s+1] <= 1'b0;
            end else begin
                r_a_vld[s+1] <= r_m_vld[s];
            end
            r_a_acc[s+1]  <= n_acc;
            r_a_last[s+1] <= r_m_last[s];
            r_a_ovf[s+1]  <= n_ovf;
        end

        // The sample is carried only as far as a later step needs it.
        if (s < MAX_DEGREE - 1) begin : g_fwd_x
            always_ff @(posedge i_clk) begin
                r_a_x[s+1] <= r_m_x[s];
            end
        end
    end

    assign o_strobe     = r_a_vld[MAX_DEGREE];
    assign o_sample_out = r_a_acc[MAX_DEGREE];
    assign o_overflow   = r_a_ovf[MAX_DEGREE];
    assign o_last_out   = r_a_last[MAX_DEGREE];

    // Every accepted word yields a result strobe at the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_strobe)
        else $error("accepted word produced no result");

    // Every result strobe belongs to an accepted word.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LATENCY))
        else $error("result strobe without accepted word");

    // The degree in use is never zero.
    a_degree_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_degree != '0)
        else $error("degree register holds zero");

    // Reset empties the pipeline: no result in the cycle after reset.
    a_reset_flush: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_strobe)
        else $error("result strobe right after reset");

    // No word is taken in the cycle following reset.
    a_busy_after_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> busy)
        else $error("busy low right after reset");

endmodule
